[hdl/pse_pkg.sv]
// package: types, codes and constants of the postfix stack evaluator
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;
  localparam int DEPTH_DEFAULT = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_REM = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;

  localparam logic [2:0] ERR_OK = 3'd0;
  localparam logic [2:0] ERR_ZERO_DIV = 3'd1;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW = 3'd3;
  localparam logic [2:0] ERR_DEPTH = 3'd4;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] operand_value;
    logic [2:0]        operator_code;
    logic              last_token;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         error_code;
  } out_item_t;

  // classified command from front to back
  typedef struct packed {
    logic               is_push;
    logic               is_op;
    logic [2:0]         op;
    logic signed [31:0] value;
    logic               last;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage : pse_pkg
`default_nettype wire

[hdl/postfix_stack_evaluator_unit.sv]
// top level: postfix stack evaluator, front queue and back stack engine
// push: IDLE, END; operator: IDLE, READ, EXEC, MUL, DIV (mul/div/rem only), END
// the back end takes a new token only in IDLE; divide and remainder use the 48-step divider
// the front queue holds four tokens so input transfers continue while the back works
// a waiting result stalls only the last token of the following expression
// reset: synchronous, clears stack count, error latch, queues; stack memory is not cleared
`timescale 1ns / 1ps
`default_nettype none
module postfix_stack_evaluator_unit import pse_pkg::*; #(
  parameter int STACK_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_item
);
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  pse_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  pse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid) else $error("command taken from empty queue");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && out_item.error_code != ERR_OK |-> out_item.result_value == 32'sd0)
    else $error("nonzero value with error");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty) else $error("result dropped");
endmodule : postfix_stack_evaluator_unit
`default_nettype wire

[hdl/pse_front.sv]
// front end: accepts tokens, classifies them and queues commands
`timescale 1ns / 1ps
`default_nettype none
module pse_front import pse_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  output logic          cmd_valid,
  input  wire logic     cmd_take,
  output cmd_t          cmd
);
  localparam int QD = 4;
  cmd_t       q [QD];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  cmd_t       c;
  logic       wr, rd;

  always_comb begin
    c.is_push = ~in_item.req_type;
    c.is_op   = in_item.req_type & (in_item.operator_code <= OP_DIV);
    c.op      = in_item.operator_code;
    c.value   = in_item.operand_value;
    c.last    = in_item.last_token;
  end

  assign full      = (cnt == 3'(QD));
  assign cmd_valid = (cnt != 3'd0);
  assign cmd       = q[rp];
  assign wr        = push & ~full;
  assign rd        = cmd_take & cmd_valid;

  always_ff @(posedge clk) begin
    if (wr) q[wp] <= c;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr) - 3'(rd);
    end
  end
endmodule : pse_front
`default_nettype wire

[hdl/pse_divider.sv]
// iterative signed divider, one quotient bit per cycle, truncating
`timescale 1ns / 1ps
`default_nettype none
module pse_divider import pse_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [47:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [48:0]      quo,
  output logic signed [31:0]      rem
);
  logic [47:0] n;
  logic [31:0] d;
  logic [48:0] r;
  logic [5:0]  k;
  logic        busy, qneg, rneg;
  logic [48:0] diff;
  logic [48:0] rs;

  assign rs   = {r[47:0], n[47]};
  assign diff = rs - {17'd0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n    <= num[47] ? 48'(-num) : num;
        d    <= den[31] ? 32'(-den) : den;
        qneg <= num[47] ^ den[31];
        rneg <= num[47];
        r    <= '0;
        k    <= 6'd48;
      end else if (busy) begin
        if (diff[48]) r <= rs;
        else r <= diff;
        n <= {n[46:0], ~diff[48]};
        k <= k - 6'd1;
        if (k == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = qneg ? -$signed({1'b0, n}) : $signed({1'b0, n});
  assign rem = rneg ? 32'(-r[31:0]) : r[31:0];
endmodule : pse_divider
`default_nettype wire

[hdl/pse_back.sv]
// back end: operand stack, arithmetic and result register
`timescale 1ns / 1ps
`default_nettype none
module pse_back import pse_pkg::*; #(
  parameter int STACK_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cmd_valid,
  output logic       cmd_take,
  input  wire cmd_t  cmd,
  output logic       empty,
  input  wire logic  pop,
  output out_item_t  out_item
);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_END  = 3'd5;

  logic signed [31:0] mem [STACK_DEPTH];
  logic signed [31:0] top, under, top_rd, under_rd;
  logic [CW-1:0]      count;
  logic [2:0]         err;
  logic [2:0]         state;
  cmd_t               cur;
  logic               outv;
  out_item_t          outq;

  logic               wen;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  logic signed [63:0] prod;
  logic               dstart, ddone;
  logic signed [47:0] dnum;
  logic signed [31:0] dden;
  logic signed [48:0] dquo;
  logic signed [31:0] drem;

  pse_divider u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo), .rem(drem)
  );

  // a waiting result only holds back the last token of the next expression
  assign cmd_take = (state == S_IDLE) && cmd_valid && !(outv && cmd.last);
  assign empty    = !outv;
  assign out_item = outq;

  // integer parts truncated toward zero
  logic signed [15:0] ia, ib;
  always_comb begin
    ia = under[31:16] + 16'((under[31] && under[15:0] != 16'd0) ? 1 : 0);
    ib = top[31:16] + 16'((top[31] && top[15:0] != 16'd0) ? 1 : 0);
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    top_rd   <= mem[AW'(count - CW'(1))];
    under_rd <= mem[AW'(count - CW'(2))];
  end

  logic signed [65:0] mres;
  assign mres = 66'(prod + 64'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    wen <= 1'b0;
    dstart <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      err   <= ERR_OK;
      outv  <= 1'b0;
    end else begin
      if (pop && outv) outv <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd_take) begin
          cur <= cmd;
          if (err != ERR_OK) state <= S_END;
          else if (cmd.is_push) begin
            if (count == CW'(STACK_DEPTH)) err <= ERR_OVERFLOW;
            else begin
              wen   <= 1'b1;
              waddr <= AW'(count);
              wdata <= cmd.value;
              count <= count + CW'(1);
            end
            state <= S_END;
          end else if (cmd.is_op) begin
            if (count < CW'(2)) begin
              err   <= ERR_UNDERFLOW;
              state <= S_END;
            end else state <= S_READ;
          end else state <= S_END;
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          top   <= top_rd;
          under <= under_rd;
          state <= S_MUL;
        end
        S_MUL: begin
          case (cur.op)
            OP_ADD, OP_SUB: begin
              wdata <= sat32(cur.op == OP_ADD ? 66'(under) + 66'(top)
                                              : 66'(under) - 66'(top));
              wen   <= 1'b1;
              waddr <= AW'(count - CW'(2));
              count <= count - CW'(1);
              state <= S_END;
            end
            OP_MUL: begin
              prod  <= under * top;
              state <= S_DIV;
              cur.op <= OP_ADD;
              cur.is_op <= 1'b0;
            end
            OP_REM: begin
              if (ib == 16'sd0) begin
                err <= ERR_ZERO_DIV;
                state <= S_END;
              end else begin
                dnum <= 48'(ia);
                dden <= 32'(ib);
                dstart <= 1'b1;
                state <= S_DIV;
              end
            end
            default: begin
              if (top == 32'sd0) begin
                err <= ERR_ZERO_DIV;
                state <= S_END;
              end else begin
                dnum <= {under, 16'd0};
                dden <= top;
                dstart <= 1'b1;
                state <= S_DIV;
              end
            end
          endcase
        end
        S_DIV: begin
          if (!cur.is_op) begin
            wdata <= sat32(mres);
            wen   <= 1'b1;
            waddr <= AW'(count - CW'(2));
            count <= count - CW'(1);
            state <= S_END;
          end else if (ddone) begin
            if (cur.op == OP_REM) wdata <= {drem[15:0], 16'd0};
            else wdata <= sat32(66'(dquo));
            wen   <= 1'b1;
            waddr <= AW'(count - CW'(2));
            count <= count - CW'(1);
            state <= S_END;
          end
        end
        S_END: begin
          state <= S_IDLE;
          if (cur.last) begin
            outv <= 1'b1;
            if (err != ERR_OK) begin
              outq.error_code <= err;
              outq.result_value <= '0;
            end else if (count != CW'(1)) begin
              outq.error_code <= ERR_DEPTH;
              outq.result_value <= '0;
            end else begin
              outq.error_code <= ERR_OK;
              outq.result_value <= (wen && waddr == AW'(0)) ? wdata : top_rd;
            end
            count <= '0;
            err   <= ERR_OK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule : pse_back
`default_nettype wire
